/* hdl/lpht_pkg.sv */
// Shared types and constants for the linear probing hash table.
// No dependencies; used by lpht_slot_ram and linear_probe_hash_table.
package lpht_pkg;

    localparam int SLOTS      = 256;
    localparam int ADDR_W     = $clog2(SLOTS);
    localparam int COUNT_W    = $clog2(SLOTS + 1);
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } t_mark;

    typedef enum logic [1:0] {
        MODE_FIND        = 2'd0,
        MODE_INSERT      = 2'd1,
        MODE_ERASE       = 2'd2,
        MODE_FIND_CREATE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_PRESENT   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_mark                 mark;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_slot;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_slot             entry;
    } t_wr_req;

endpackage

/* hdl/lpht_slot_ram.sv */
// Slot store: one synchronous memory of {mark, key, value} per slot.
// Per-slot written bits make unwritten slots read as empty after reset.
// Depends on lpht_pkg.
module lpht_slot_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [lpht_pkg::ADDR_W-1:0] i_rd_addr,
    input  lpht_pkg::t_wr_req i_wr,
    output lpht_pkg::t_slot   o_rd_data
);

    lpht_pkg::t_slot              r_mem [lpht_pkg::SLOTS];
    lpht_pkg::t_slot              r_rd_entry;
    logic [lpht_pkg::SLOTS-1:0]   r_written;
    logic                         r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        r_rd_entry <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_written[i_wr.addr] <= 1'b1;
            end
            r_rd_written <= r_written[i_rd_addr];
        end
    end

    // a slot never written since reset is empty
    always_comb begin
        o_rd_data = r_rd_entry;
        if (!r_rd_written) begin
            o_rd_data.mark  = lpht_pkg::MARK_EMPTY;
            o_rd_data.key   = '0;
            o_rd_data.value = '0;
        end
    end

endmodule

/* hdl/linear_probe_hash_table.sv */
// Top level of the open addressing key/value table with linear probing.
// Depends on lpht_pkg and lpht_slot_ram.
//
// Input channel: i_in_valid / o_in_stall carry mode, key and value.
// Output channel: o_out_valid / i_out_stall carry status, result_value
// and stored_count. One result transaction per input transaction.
//
// Each transaction probes one slot per cycle, starting at the home slot
// (low key bits) and walking forward with wraparound, until an empty slot,
// a matching key, or all slots have been seen. The single memory read
// port sets the pace: a transaction makes 1 to SLOTS probes, and no new
// transaction is taken until the result of the last one is registered.
// Any slot update is written back in the cycle of the last probe.
//
// Reset clears all slot marks to empty at once and the stored count to
// zero; the block accepts work in the first cycle after reset.
// While a result waits under i_out_stall, a new transaction is taken only
// in the cycle the waiting result is taken.
module linear_probe_hash_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_in_mode,
    input  logic [31:0] i_in_key,
    input  logic [31:0] i_in_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_out_status,
    output logic [31:0] o_out_result_value,
    output logic [8:0]  o_out_stored_count
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_PROBE = 2'b10
    } t_state;

    localparam int AW = lpht_pkg::ADDR_W;
    localparam int CW = lpht_pkg::COUNT_W;

    t_state                              r_state, n_state;
    lpht_pkg::t_mode                     r_mode, n_mode;
    logic [lpht_pkg::KEY_BITS-1:0]       r_key, n_key;
    logic [lpht_pkg::VALUE_BITS-1:0]     r_value, n_value;
    logic [AW-1:0]                       r_probe, n_probe;
    logic [AW-1:0]                       r_steps, n_steps;
    logic                                r_free_found, n_free_found;
    logic [AW-1:0]                       r_free_slot, n_free_slot;
    logic [CW-1:0]                       r_count, n_count;
    logic                                r_out_valid, n_out_valid;
    lpht_pkg::t_status                   r_status, n_status;
    logic [lpht_pkg::VALUE_BITS-1:0]     r_result, n_result;

    logic              w_in_accept;
    logic [AW-1:0]     w_rd_addr;
    lpht_pkg::t_slot   w_rd;
    lpht_pkg::t_wr_req w_wr;
    logic              w_used, w_empty, w_match, w_done;
    logic              w_free_found;
    logic [AW-1:0]     w_free_slot;

    lpht_slot_ram u_slot_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_wr      (w_wr),
        .o_rd_data (w_rd)
    );

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // probe evaluation on the slot read last cycle
    assign w_used       = (w_rd.mark == lpht_pkg::MARK_USED);
    assign w_empty      = (w_rd.mark == lpht_pkg::MARK_EMPTY);
    assign w_match      = w_used && (w_rd.key == r_key);
    assign w_done       = w_empty || w_match || (&r_steps);
    assign w_free_found = r_free_found || !w_used;
    assign w_free_slot  = r_free_found ? r_free_slot : r_probe;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_value      = r_value;
        n_probe      = r_probe;
        n_steps      = r_steps;
        n_free_found = r_free_found;
        n_free_slot  = r_free_slot;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_result     = r_result;
        w_rd_addr    = r_probe;
        w_wr         = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_mode       = lpht_pkg::t_mode'(i_in_mode);
                    n_key        = i_in_key;
                    n_value      = i_in_value;
                    n_probe      = i_in_key[AW-1:0];
                    n_steps      = '0;
                    n_free_found = 1'b0;
                    w_rd_addr    = i_in_key[AW-1:0];
                    n_state      = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!w_done) begin
                    n_probe      = r_probe + 1'b1;
                    n_steps      = r_steps + 1'b1;
                    n_free_found = w_free_found;
                    n_free_slot  = w_free_slot;
                    w_rd_addr    = r_probe + 1'b1;
                end else begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = lpht_pkg::ST_OK;
                    n_result    = '0;
                    case (r_mode)
                        lpht_pkg::MODE_FIND: begin
                            if (w_match) begin
                                n_result = w_rd.value;
                            end else begin
                                n_status = lpht_pkg::ST_NOT_FOUND;
                            end
                        end
                        lpht_pkg::MODE_ERASE: begin
                            if (w_match) begin
                                w_wr.en          = 1'b1;
                                w_wr.addr        = r_probe;
                                w_wr.entry.mark  = lpht_pkg::MARK_DELETED;
                                w_wr.entry.key   = w_rd.key;
                                w_wr.entry.value = w_rd.value;
                                n_count          = r_count - 1'b1;
                            end else begin
                                n_status = lpht_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            // insert and find-or-create share placement
                            if (w_match) begin
                                n_result = w_rd.value;
                                if (r_mode == lpht_pkg::MODE_INSERT) begin
                                    n_status = lpht_pkg::ST_PRESENT;
                                end
                            end else if (w_free_found) begin
                                w_wr.en         = 1'b1;
                                w_wr.addr       = w_free_slot;
                                w_wr.entry.mark = lpht_pkg::MARK_USED;
                                w_wr.entry.key  = r_key;
                                w_wr.entry.value = (r_mode == lpht_pkg::MODE_INSERT)
                                                   ? r_value : '0;
                                n_result        = w_wr.entry.value;
                                n_count         = r_count + 1'b1;
                            end else begin
                                n_status = lpht_pkg::ST_FULL;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_value      <= n_value;
        r_probe      <= n_probe;
        r_steps      <= n_steps;
        r_free_found <= n_free_found;
        r_free_slot  <= n_free_slot;
        r_status     <= n_status;
        r_result     <= n_result;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_status       = r_status;
    assign o_out_result_value = r_result;
    assign o_out_stored_count = r_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(lpht_pkg::SLOTS))
        else $error("stored count above slot count");

    a_write_only_probing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (r_state == S_PROBE) && w_done)
        else $error("slot write outside final probe");

    a_full_means_all_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_status == lpht_pkg::ST_FULL)
            |-> (o_out_stored_count == CW'(lpht_pkg::SLOTS)))
        else $error("table full reported with free slots");

    a_accept_starts_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == S_PROBE) && !r_out_valid)
        else $error("accepted transaction did not start probing");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_count == $past(r_count)))
        else $error("stored count changed while idle");

endmodule

/* tb/tb_linear_probe_hash_table.sv */
`timescale 1ns / 100ps
// Self-checking testbench for linear_probe_hash_table: directed and random table operations.
// Depends on lpht_pkg and the RTL of linear_probe_hash_table; a local table model predicts results.
module tb_linear_probe_hash_table;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = lpht_pkg::SLOTS + 50;
    localparam int MAX_GAP      = 20;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        lpht_pkg::t_status status;
        logic [31:0]       value;
        logic [8:0]        count;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_in_mode = 2'd0;
    logic [31:0] i_in_key = '0;
    logic [31:0] i_in_value = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_out_status;
    logic [31:0] o_out_result_value;
    logic [8:0]  o_out_stored_count;

    // table model
    logic [31:0]     model_key [lpht_pkg::SLOTS];
    logic [31:0]     model_value [lpht_pkg::SLOTS];
    lpht_pkg::t_mark model_mark [lpht_pkg::SLOTS];
    int              model_count = 0;
    int              peak_count = 0;

    t_reply      pending_replies [$];
    t_reply      oldest_reply;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          ops_sent = 0;
    int          replies_seen = 0;
    int          errors = 0;
    int          cycle_count = 0;
    int          status_seen [4] = '{default: 0};

    linear_probe_hash_table dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_mode          (i_in_mode),
        .i_in_key           (i_in_key),
        .i_in_value         (i_in_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_status       (o_out_status),
        .o_out_result_value (o_out_result_value),
        .o_out_stored_count (o_out_stored_count)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_replies.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Slot holding the key, or -1; tombstones are passed over
    function automatic int locate_key(logic [31:0] key);
        int s;
        for (int j = 0; j < lpht_pkg::SLOTS; j++) begin
            s = (int'(key[lpht_pkg::ADDR_W-1:0]) + j) % lpht_pkg::SLOTS;
            if (model_mark[s] == lpht_pkg::MARK_EMPTY) return -1;
            if (model_mark[s] == lpht_pkg::MARK_USED && model_key[s] == key) return s;
        end
        return -1;
    endfunction

    function automatic bit claim_slot(logic [31:0] key, logic [31:0] value);
        int s;
        for (int j = 0; j < lpht_pkg::SLOTS; j++) begin
            s = (int'(key[lpht_pkg::ADDR_W-1:0]) + j) % lpht_pkg::SLOTS;
            if (model_mark[s] != lpht_pkg::MARK_USED) begin
                model_key[s]   = key;
                model_value[s] = value;
                model_mark[s]  = lpht_pkg::MARK_USED;
                model_count++;
                if (model_count > peak_count) peak_count = model_count;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_reply apply_table_op(lpht_pkg::t_mode mode, logic [31:0] key,
                                              logic [31:0] value);
        t_reply r;
        int     hit;
        hit      = locate_key(key);
        r.status = lpht_pkg::ST_OK;
        r.value  = '0;
        case (mode)
            lpht_pkg::MODE_FIND: begin
                if (hit >= 0) r.value = model_value[hit];
                else r.status = lpht_pkg::ST_NOT_FOUND;
            end
            lpht_pkg::MODE_INSERT: begin
                if (hit >= 0) begin
                    r.status = lpht_pkg::ST_PRESENT;
                    r.value  = model_value[hit];
                end else if (claim_slot(key, value)) begin
                    r.value = value;
                end else begin
                    r.status = lpht_pkg::ST_FULL;
                end
            end
            lpht_pkg::MODE_ERASE: begin
                if (hit >= 0) begin
                    model_mark[hit] = lpht_pkg::MARK_DELETED;
                    model_count--;
                end else begin
                    r.status = lpht_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                if (hit >= 0) r.value = model_value[hit];
                else if (!claim_slot(key, '0)) r.status = lpht_pkg::ST_FULL;
            end
        endcase
        r.count = model_count[8:0];
        return r;
    endfunction

    // Any key currently held, scanning from a random slot; a random key if none is held
    function automatic logic [31:0] some_stored_key();
        int start;
        start = $urandom_range(lpht_pkg::SLOTS - 1);
        for (int j = 0; j < lpht_pkg::SLOTS; j++) begin
            if (model_mark[(start + j) % lpht_pkg::SLOTS] == lpht_pkg::MARK_USED)
                return model_key[(start + j) % lpht_pkg::SLOTS];
        end
        return $urandom();
    endfunction

    // Held keys, two narrow home-slot windows (one wrapping past the end) and random keys
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 40 && model_count != 0) return some_stored_key();
        if (r < 62) return {24'($urandom_range(3)), 8'($urandom_range(40, 55))};
        if (r < 80) return {24'($urandom_range(3)), 8'(250 + $urandom_range(9))};
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_op(input lpht_pkg::t_mode mode, input logic [31:0] key,
                           input logic [31:0] value);
        int     gap;
        t_reply expected;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_mode  <= mode;
        i_in_key   <= key;
        i_in_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected = apply_table_op(mode, key, value);
        pending_replies.insert(pending_replies.size(), expected);
        ops_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            replies_seen++;
            status_seen[o_out_status]++;
            if (pending_replies.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, status %0d value %h count %0d",
                             $time, o_out_status, o_out_result_value, o_out_stored_count);
            end else begin
                oldest_reply = pending_replies.pop_front();
                if (o_out_status !== oldest_reply.status) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: status expected %0d got %0d", $time,
                                 oldest_reply.status, o_out_status);
                end
                if (o_out_result_value !== oldest_reply.value) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result_value expected %h got %h", $time,
                                 oldest_reply.value, o_out_result_value);
                end
                if (o_out_stored_count !== oldest_reply.count) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: stored_count expected %0d got %0d", $time,
                                 oldest_reply.count, o_out_stored_count);
                end
            end
        end
    end

    task automatic test_empty_table();
        send_op(lpht_pkg::MODE_FIND, 32'h0000_0000, 32'h0000_0000);
        send_op(lpht_pkg::MODE_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(lpht_pkg::MODE_FIND, 32'h8000_0080, 32'h0000_0000);
    endtask

    task automatic test_insert_and_lookup();
        send_op(lpht_pkg::MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(lpht_pkg::MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_op(lpht_pkg::MODE_FIND, 32'h0000_0000, 32'h0000_0000);
        send_op(lpht_pkg::MODE_FIND_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(lpht_pkg::MODE_FIND_CREATE, 32'hFFFF_FFFF, 32'h0000_0000);
        // home slot is the last one, taken: probe wraps to slot 1
        send_op(lpht_pkg::MODE_INSERT, 32'h0000_01FF, 32'h1234_5678);
        send_op(lpht_pkg::MODE_FIND, 32'h0000_01FF, 32'h0000_0000);
    endtask

    task automatic test_probe_chains();
        send_op(lpht_pkg::MODE_ERASE, 32'h0000_0000, 32'h0000_0000);
        send_op(lpht_pkg::MODE_FIND, 32'h0000_01FF, 32'h0000_0000);
        send_op(lpht_pkg::MODE_ERASE, 32'h0000_0000, 32'h0000_0000);
        // absent key reuses the tombstone at its home slot
        send_op(lpht_pkg::MODE_FIND_CREATE, 32'h0000_0100, 32'hDEAD_BEEF);
        send_op(lpht_pkg::MODE_INSERT, 32'h0000_0100, 32'h0000_0005);
        send_op(lpht_pkg::MODE_ERASE, 32'h0000_01FF, 32'h0000_0000);
        send_op(lpht_pkg::MODE_ERASE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_op(lpht_pkg::MODE_INSERT, 32'h0000_02FF, 32'hA5A5_A5A5);
        send_op(lpht_pkg::MODE_FIND, 32'h0000_01FF, 32'h0000_0000);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) send_op(lpht_pkg::t_mode'($urandom_range(3)), pick_key(), pick_value());
    endtask

    task automatic test_fill_until_full();
        while (model_count < lpht_pkg::SLOTS) begin
            if ($urandom_range(7) == 0)
                send_op(lpht_pkg::MODE_FIND_CREATE, $urandom(), pick_value());
            else
                send_op(lpht_pkg::MODE_INSERT, $urandom(), pick_value());
        end
    endtask

    task automatic test_full_table();
        send_op(lpht_pkg::MODE_INSERT, $urandom(), pick_value());
        send_op(lpht_pkg::MODE_FIND_CREATE, $urandom(), pick_value());
        send_op(lpht_pkg::MODE_FIND, $urandom(), pick_value());
        send_op(lpht_pkg::MODE_INSERT, some_stored_key(), pick_value());
        send_op(lpht_pkg::MODE_FIND_CREATE, some_stored_key(), pick_value());
        send_op(lpht_pkg::MODE_ERASE, some_stored_key(), pick_value());
        send_op(lpht_pkg::MODE_INSERT, $urandom(), pick_value());
        send_op(lpht_pkg::MODE_INSERT, $urandom(), pick_value());
    endtask

    // Leaves the table half full of tombstones with no empty slot left
    task automatic test_drain_half();
        for (int i = 0; i < 170; i++) begin
            if (i % 4 == 3)
                send_op(lpht_pkg::MODE_FIND, some_stored_key(), pick_value());
            else
                send_op(lpht_pkg::MODE_ERASE, some_stored_key(), pick_value());
        end
    endtask

    initial begin
        foreach (model_mark[i]) model_mark[i] = lpht_pkg::MARK_EMPTY;
        send_idle_pct  = 25;
        recv_stall_pct = 77;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_insert_and_lookup();
        test_probe_chains();
        test_random_mix(320);

        send_idle_pct  = 77;
        recv_stall_pct = 25;
        test_fill_until_full();
        test_full_table();
        test_drain_half();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_mix(440);
        i_in_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d transactions, %0d results: ok %0d, not found %0d, present %0d, full %0d",
                 ops_sent, replies_seen, status_seen[lpht_pkg::ST_OK],
                 status_seen[lpht_pkg::ST_NOT_FOUND], status_seen[lpht_pkg::ST_PRESENT],
                 status_seen[lpht_pkg::ST_FULL]);
        $display("Peak occupancy %0d of %0d slots, %0d mismatches", peak_count,
                 lpht_pkg::SLOTS, errors);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
